@@ sv/connection_slot_table_unit_defines.svh @@
// assertion helpers used by the connection slot table unit
`ifndef CONNECTION_SLOT_TABLE_UNIT_DEFINES_SVH
`define CONNECTION_SLOT_TABLE_UNIT_DEFINES_SVH

// checked on every rising edge outside reset
`define CST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define CST_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/cst_pkg.sv @@
package cst_pkg;

    localparam int MODE_W   = 2;
    localparam int HANDLE_W = 20;
    localparam int ID_W     = 64;
    localparam int STATUS_W = 3;
    localparam int CAP_W    = 6;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam int IN_FIELDS_W = MODE_W + HANDLE_W + ID_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd63;

    // register index taken from paddr above the byte offset
    localparam logic [ADDR_W-3:0] REG_ALLOC_LIMIT = 1'b0;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC       = 2'd0,
        MODE_RELEASE     = 2'd1,
        MODE_FIND_HANDLE = 2'd2,
        MODE_FIND_ID     = 2'd3
    } cst_mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_HANDLE_USED = 3'd1,
        ST_ID_USED     = 3'd2,
        ST_FULL        = 3'd3,
        ST_NOT_FOUND   = 3'd4
    } cst_status_t;

    typedef struct packed {
        logic handle_hit;
        logic id_hit;
        logic free_hit;
    } cst_hits_t;

endpackage

@@ sv/cst_match.sv @@
module cst_match #(
    parameter int SLOTS = 64
) (
    input  logic [SLOTS-1:0]              slot_valid,
    input  logic [cst_pkg::HANDLE_W-1:0]  slot_handle [SLOTS],
    input  logic [cst_pkg::ID_W-1:0]      slot_id [SLOTS],
    input  logic [cst_pkg::HANDLE_W-1:0]  key_handle,
    input  logic [cst_pkg::ID_W-1:0]      key_id,
    input  logic [cst_pkg::CAP_W-1:0]     alloc_limit,
    output cst_pkg::cst_hits_t            hits,
    output logic [SLOTS-1:0]              handle_sel,
    output logic [SLOTS-1:0]              id_sel,
    output logic [SLOTS-1:0]              free_sel
);

    localparam logic [SLOTS-1:0] ONE = SLOTS'(1);

    logic [SLOTS-1:0] handle_eq;
    logic [SLOTS-1:0] id_eq;
    logic [SLOTS-1:0] free_vec;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            handle_eq[i] = slot_valid[i] && (slot_handle[i] == key_handle);
            id_eq[i]     = slot_valid[i] && (slot_id[i] == key_id);
            free_vec[i]  = !slot_valid[i] && (i <= int'(alloc_limit));
        end
    end

    // keep only the lowest set bit of each vector
    assign handle_sel = handle_eq & (~handle_eq + ONE);
    assign id_sel     = id_eq & (~id_eq + ONE);
    assign free_sel   = free_vec & (~free_vec + ONE);

    assign hits.handle_hit = |handle_eq;
    assign hits.id_hit     = |id_eq;
    assign hits.free_hit   = |free_vec;

endmodule

@@ sv/connection_slot_table_unit.sv @@
// Connection slot table: SLOTS slots, each with a valid mark, a 20-bit socket handle and a
// 64-bit global id, matched in parallel on every operation. Input transaction tdata carries
// mode (allocate, release by handle, lookup by handle, lookup by id), handle and global id;
// each input gives exactly one output transaction with status, slot index, the slot's id and
// handle, and the live slot count after the operation. Allocate takes the lowest free slot in
// 0..alloc_limit and refuses a handle or id already present. One operation completes per
// cycle while the output is not stalled: an input register feeds the parallel key compare,
// lowest-slot priority pick and table update, which finish in the same cycle into the result
// register. Valid marks are flip-flops cleared by reset; there is no clearing pass and the
// table is usable right after reset. alloc_limit is written over the APB port at address 0;
// the user must write it only while the block is idle, which the block does not enforce.
`include "connection_slot_table_unit_defines.svh"

module connection_slot_table_unit #(
    parameter int SLOTS = 64,
    localparam int IDX_W = $clog2(SLOTS),
    localparam int CNT_W = $clog2(SLOTS + 1),
    localparam int OUT_FIELDS_W = cst_pkg::STATUS_W + IDX_W + cst_pkg::ID_W
                                  + cst_pkg::HANDLE_W + CNT_W,
    localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cst_pkg::ADDR_W-1:0]       paddr,
    input  logic [cst_pkg::DATA_W-1:0]       pwdata,
    output logic [cst_pkg::DATA_W-1:0]       prdata,
    output logic                             pready,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // mode, handle, global_id (lowest bit up), zero padded
    input  logic [cst_pkg::IN_TDATA_W-1:0]   s_tdata,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status, slot_index, found_id, found_handle, live_total (lowest bit up), zero padded
    output logic [OUT_TDATA_W-1:0]           m_tdata
);

    // configuration
    logic [cst_pkg::CAP_W-1:0] alloc_limit_reg;
    logic                      cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[cst_pkg::ADDR_W-1:2] == cst_pkg::REG_ALLOC_LIMIT);
    assign prdata    = (paddr[cst_pkg::ADDR_W-1:2] == cst_pkg::REG_ALLOC_LIMIT)
                       ? cst_pkg::DATA_W'(alloc_limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_limit_reg <= cst_pkg::CAP_RESET;
        end
        else if (cfg_write)
        begin
            alloc_limit_reg <= pwdata[cst_pkg::CAP_W-1:0];
        end
    end

    // input register
    logic                             in_valid_reg;
    cst_pkg::cst_mode_t               in_mode_reg;
    logic [cst_pkg::HANDLE_W-1:0]     in_handle_reg;
    logic [cst_pkg::ID_W-1:0]         in_id_reg;
    logic                             process;
    logic                             out_valid_reg;

    assign process  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || process;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_mode_reg   <= cst_pkg::cst_mode_t'(s_tdata[cst_pkg::MODE_W-1:0]);
            in_handle_reg <= s_tdata[cst_pkg::MODE_W +: cst_pkg::HANDLE_W];
            in_id_reg     <= s_tdata[cst_pkg::MODE_W + cst_pkg::HANDLE_W +: cst_pkg::ID_W];
        end
    end

    // slot table
    logic [SLOTS-1:0]             slot_valid_reg;
    logic [SLOTS-1:0]             slot_valid_next;
    logic [cst_pkg::HANDLE_W-1:0] slot_handle_reg [SLOTS];
    logic [cst_pkg::ID_W-1:0]     slot_id_reg [SLOTS];
    logic [CNT_W-1:0]             live_reg;
    logic [CNT_W-1:0]             live_next;

    cst_pkg::cst_hits_t hits;
    logic [SLOTS-1:0]   handle_sel;
    logic [SLOTS-1:0]   id_sel;
    logic [SLOTS-1:0]   free_sel;

    cst_match #(
        .SLOTS(SLOTS)
    ) u_match (
        .slot_valid    (slot_valid_reg),
        .slot_handle   (slot_handle_reg),
        .slot_id       (slot_id_reg),
        .key_handle    (in_handle_reg),
        .key_id        (in_id_reg),
        .alloc_limit   (alloc_limit_reg),
        .hits          (hits),
        .handle_sel    (handle_sel),
        .id_sel        (id_sel),
        .free_sel      (free_sel)
    );

    // operation decode
    cst_pkg::cst_status_t          status_next;
    logic [SLOTS-1:0]              sel;
    logic                          do_alloc;
    logic                          do_release;
    logic [IDX_W-1:0]              slot_index_next;
    logic [cst_pkg::ID_W-1:0]      found_id_next;
    logic [cst_pkg::HANDLE_W-1:0]  found_handle_next;

    always_comb
    begin
        status_next = cst_pkg::ST_OK;
        sel         = '0;
        do_alloc    = 1'b0;
        do_release  = 1'b0;
        unique case (in_mode_reg)
            cst_pkg::MODE_ALLOC:
            begin
                if (hits.handle_hit)
                begin
                    status_next = cst_pkg::ST_HANDLE_USED;
                end
                else if (hits.id_hit)
                begin
                    status_next = cst_pkg::ST_ID_USED;
                end
                else if (!hits.free_hit)
                begin
                    status_next = cst_pkg::ST_FULL;
                end
                else
                begin
                    sel      = free_sel;
                    do_alloc = 1'b1;
                end
            end
            cst_pkg::MODE_RELEASE:
            begin
                if (hits.handle_hit)
                begin
                    sel        = handle_sel;
                    do_release = 1'b1;
                end
                else
                begin
                    status_next = cst_pkg::ST_NOT_FOUND;
                end
            end
            cst_pkg::MODE_FIND_HANDLE:
            begin
                if (hits.handle_hit)
                begin
                    sel = handle_sel;
                end
                else
                begin
                    status_next = cst_pkg::ST_NOT_FOUND;
                end
            end
            cst_pkg::MODE_FIND_ID:
            begin
                if (hits.id_hit)
                begin
                    sel = id_sel;
                end
                else
                begin
                    status_next = cst_pkg::ST_NOT_FOUND;
                end
            end
            default:
            begin
                status_next = cst_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    // one-hot encode and and-or readout; sel is zero on any failure
    always_comb
    begin
        slot_index_next   = '0;
        found_id_next     = '0;
        found_handle_next = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_index_next   = slot_index_next | ({IDX_W{sel[i]}} & IDX_W'(i));
            found_id_next     = found_id_next | ({cst_pkg::ID_W{sel[i]}} & slot_id_reg[i]);
            found_handle_next = found_handle_next
                                | ({cst_pkg::HANDLE_W{sel[i]}} & slot_handle_reg[i]);
        end
        // a fresh allocation echoes the keys being stored
        if (do_alloc)
        begin
            found_id_next     = in_id_reg;
            found_handle_next = in_handle_reg;
        end
    end

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        live_next       = live_reg;
        if (do_alloc)
        begin
            slot_valid_next = slot_valid_reg | sel;
            live_next       = live_reg + CNT_W'(1);
        end
        else if (do_release)
        begin
            slot_valid_next = slot_valid_reg & ~sel;
            live_next       = live_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            live_reg       <= '0;
        end
        else if (process)
        begin
            slot_valid_reg <= slot_valid_next;
            live_reg       <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            if (process && do_alloc && sel[i])
            begin
                slot_handle_reg[i] <= in_handle_reg;
                slot_id_reg[i]     <= in_id_reg;
            end
        end
    end

    // result register
    cst_pkg::cst_status_t          status_reg;
    logic [IDX_W-1:0]              slot_index_reg;
    logic [cst_pkg::ID_W-1:0]      found_id_reg;
    logic [cst_pkg::HANDLE_W-1:0]  found_handle_reg;
    logic [CNT_W-1:0]              live_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (process)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            status_reg       <= status_next;
            slot_index_reg   <= slot_index_next;
            found_id_reg     <= found_id_next;
            found_handle_reg <= found_handle_next;
            live_total_reg   <= live_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({live_total_reg, found_handle_reg, found_id_reg,
                                    slot_index_reg, status_reg});

    `CST_ASSERT(a_fail_fields_zero,
        (m_tvalid && (status_reg != cst_pkg::ST_OK)) |->
            ((slot_index_reg == '0) && (found_id_reg == '0) && (found_handle_reg == '0)),
        "failed operation reports nonzero slot fields")

    `CST_ASSERT_ALWAYS(a_live_matches_valid,
        $countones(slot_valid_reg) == int'(live_reg),
        "live count differs from number of valid slots")

    `CST_ASSERT(a_alloc_marks_valid,
        (process && do_alloc) |=> slot_valid_reg[slot_index_reg],
        "allocated slot not marked valid")

    `CST_ASSERT(a_input_held,
        (in_valid_reg && !process) |=> (in_valid_reg && $stable(in_handle_reg)),
        "pending input lost while output stalled")

endmodule

@@ sim/tb_connection_slot_table_unit.sv @@
`timescale 1ns / 1ps

module tb_connection_slot_table_unit;

    localparam int HANDLE_W = cst_pkg::HANDLE_W;
    localparam int ID_W = cst_pkg::ID_W;
    localparam int STATUS_W = cst_pkg::STATUS_W;
    localparam int CAP_W = cst_pkg::CAP_W;
    localparam int ADDR_W = cst_pkg::ADDR_W;
    localparam int DATA_W = cst_pkg::DATA_W;
    localparam int IN_FIELDS_W = cst_pkg::IN_FIELDS_W;
    localparam int IN_TDATA_W = cst_pkg::IN_TDATA_W;
    localparam int SLOTS = 64;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int REPLY_FIELDS_W = STATUS_W + IDX_W + ID_W + HANDLE_W + CNT_W;
    localparam int REPLY_W = ((REPLY_FIELDS_W + 7) / 8) * 8;
    localparam int SLOT_LSB = STATUS_W;
    localparam int ID_LSB = SLOT_LSB + IDX_W;
    localparam int HND_LSB = ID_LSB + ID_W;
    localparam int CNT_LSB = HND_LSB + HANDLE_W;
    localparam int POOL_KEYS = 24;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 4;

    localparam logic [HANDLE_W-1:0] HANDLE_MAX = '1;
    localparam logic [ID_W-1:0] ID_MAX = '1;

    typedef struct packed {
        cst_pkg::cst_status_t status;
        logic [IDX_W-1:0]     slot;
        logic [ID_W-1:0]      id;
        logic [HANDLE_W-1:0]  handle;
        logic [CNT_W-1:0]     live;
    } slot_reply_t;

    function automatic logic [HANDLE_W-1:0] rand_handle();
        logic [31:0] r;
        r = $urandom;
        return r[HANDLE_W-1:0];
    endfunction

    class conn_table_tracker;
        bit                  valid_q [SLOTS];
        bit [HANDLE_W-1:0]   handle_q [SLOTS];
        bit [ID_W-1:0]       id_q [SLOTS];
        int unsigned         live_slots = 0;
        int unsigned         peak_live = 0;
        bit [CAP_W-1:0]      capacity = cst_pkg::CAP_RESET;
        slot_reply_t         pending [$];
        int                  errors = 0;
        int                  ops_seen = 0;
        int                  status_seen [5];

        function int find_handle_slot(logic [HANDLE_W-1:0] h);
            for (int i = 0; i < SLOTS; i++)
                if (valid_q[i] && handle_q[i] == h)
                    return i;
            return -1;
        endfunction

        function int find_id_slot(logic [ID_W-1:0] g);
            for (int i = 0; i < SLOTS; i++)
                if (valid_q[i] && id_q[i] == g)
                    return i;
            return -1;
        endfunction

        function int find_free_slot();
            int limit;
            limit = int'(capacity) + 1;
            if (limit > SLOTS)
                limit = SLOTS;
            for (int i = 0; i < limit; i++)
                if (!valid_q[i])
                    return i;
            return -1;
        endfunction

        // random valid slot's keys, for lookups and releases that hit
        function bit pick_live(output logic [HANDLE_W-1:0] h, output logic [ID_W-1:0] g);
            int idx [$];
            int k;
            h = '0;
            g = '0;
            for (int i = 0; i < SLOTS; i++)
                if (valid_q[i])
                    idx.push_back(i);
            if (idx.size() == 0)
                return 0;
            k = idx[$urandom_range(idx.size() - 1)];
            h = handle_q[k];
            g = id_q[k];
            return 1;
        endfunction

        function void note_op(cst_pkg::cst_mode_t mode, logic [HANDLE_W-1:0] h,
                              logic [ID_W-1:0] g);
            slot_reply_t want;
            int slot;
            want = '0;
            want.status = cst_pkg::ST_OK;
            slot = -1;
            case (mode)
                cst_pkg::MODE_ALLOC:
                begin
                    if (find_handle_slot(h) >= 0)
                        want.status = cst_pkg::ST_HANDLE_USED;
                    else if (find_id_slot(g) >= 0)
                        want.status = cst_pkg::ST_ID_USED;
                    else
                    begin
                        slot = find_free_slot();
                        if (slot < 0)
                            want.status = cst_pkg::ST_FULL;
                        else
                        begin
                            valid_q[slot] = 1'b1;
                            handle_q[slot] = h;
                            id_q[slot] = g;
                            live_slots++;
                        end
                    end
                end
                cst_pkg::MODE_RELEASE:
                begin
                    slot = find_handle_slot(h);
                    if (slot < 0)
                        want.status = cst_pkg::ST_NOT_FOUND;
                    else
                    begin
                        valid_q[slot] = 1'b0;
                        live_slots--;
                    end
                end
                cst_pkg::MODE_FIND_HANDLE:
                begin
                    slot = find_handle_slot(h);
                    if (slot < 0)
                        want.status = cst_pkg::ST_NOT_FOUND;
                end
                default:
                begin
                    slot = find_id_slot(g);
                    if (slot < 0)
                        want.status = cst_pkg::ST_NOT_FOUND;
                end
            endcase
            // released slots still report the keys they held
            if (want.status == cst_pkg::ST_OK)
            begin
                want.slot = slot[IDX_W-1:0];
                want.id = id_q[slot];
                want.handle = handle_q[slot];
            end
            want.live = live_slots[CNT_W-1:0];
            if (live_slots > peak_live)
                peak_live = live_slots;
            ops_seen++;
            status_seen[int'(want.status)]++;
            pending.push_back(want);
        endfunction

        function void check_reply(logic [REPLY_W-1:0] data);
            slot_reply_t want;
            if (pending.size() == 0)
            begin
                $error("output transaction with nothing outstanding: %h", data);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (data[STATUS_W-1:0] !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, data[STATUS_W-1:0]);
                errors++;
            end
            if (data[SLOT_LSB +: IDX_W] !== want.slot)
            begin
                $error("slot_index: expected %0d, actual %0d", want.slot,
                       data[SLOT_LSB +: IDX_W]);
                errors++;
            end
            if (data[ID_LSB +: ID_W] !== want.id)
            begin
                $error("found_id: expected %h, actual %h", want.id, data[ID_LSB +: ID_W]);
                errors++;
            end
            if (data[HND_LSB +: HANDLE_W] !== want.handle)
            begin
                $error("found_handle: expected %h, actual %h", want.handle,
                       data[HND_LSB +: HANDLE_W]);
                errors++;
            end
            if (data[CNT_LSB +: CNT_W] !== want.live)
            begin
                $error("live_total: expected %0d, actual %0d", want.live,
                       data[CNT_LSB +: CNT_W]);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_W-1:0]      paddr;
    logic [DATA_W-1:0]      pwdata;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;
    logic                   s_tvalid;
    logic                   s_tready;
    // mode, handle, global_id (lowest bit up), zero padded
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // status, slot_index, found_id, found_handle, live_total (lowest bit up), zero padded
    logic [REPLY_W-1:0]     m_tdata;

    conn_table_tracker      table_model;
    int                     src_idle_pct = 0;
    int                     dst_idle_pct = 0;
    int                     stall_cycles = 0;
    logic [HANDLE_W-1:0]    handle_pool [POOL_KEYS];
    logic [ID_W-1:0]        id_pool [POOL_KEYS];

    connection_slot_table_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= dst_idle_pct);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            table_model.check_reply(m_tdata);

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $error("no transaction for %0d cycles", stall_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_op(cst_pkg::cst_mode_t mode, logic [HANDLE_W-1:0] h,
                           logic [ID_W-1:0] g);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, g, h, mode};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        table_model.note_op(mode, h, g);
    endtask

    // hold off input until every outstanding reply is back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (table_model.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {cst_pkg::REG_ALLOC_LIMIT, 2'b00};
        pwdata <= {{(DATA_W - CAP_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        table_model.capacity = value;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {{(DATA_W - CAP_W){1'b0}}, value})
        begin
            $error("alloc_limit: expected %0d, actual %0d", value, prdata);
            table_model.errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_traffic(int items, int alloc_pct);
        logic [HANDLE_W-1:0] h;
        logic [HANDLE_W-1:0] lh;
        logic [ID_W-1:0]     g;
        logic [ID_W-1:0]     lg;
        int                  r;
        int                  k;
        bit                  have_live;
        cst_pkg::cst_mode_t  mode;
        for (int n = 0; n < items; n++)
        begin
            have_live = table_model.pick_live(lh, lg);
            k = $urandom_range(POOL_KEYS - 1);
            h = rand_handle();
            g = {$urandom, $urandom};
            if ($urandom_range(99) < alloc_pct)
            begin
                mode = cst_pkg::MODE_ALLOC;
                r = $urandom_range(99);
                // mostly paired keys, some fresh ones, some clashing on one key
                if (r < 55)
                begin
                    h = handle_pool[k];
                    g = id_pool[k];
                end
                else if (r >= 80 && r < 90 && have_live)
                    h = lh;
                else if (r >= 90 && have_live)
                    g = lg;
            end
            else
            begin
                mode = cst_pkg::cst_mode_t'($urandom_range(int'(cst_pkg::MODE_RELEASE),
                                                           int'(cst_pkg::MODE_FIND_ID)));
                r = $urandom_range(99);
                if (r < 60 && have_live)
                begin
                    if (mode == cst_pkg::MODE_FIND_ID)
                        g = lg;
                    else
                        h = lh;
                end
                else if (r < 85)
                begin
                    h = handle_pool[k];
                    g = id_pool[k];
                end
            end
            push_op(mode, h, g);
        end
    endtask

    initial
    begin
        table_model = new();
        handle_pool[0] = '0;
        handle_pool[1] = HANDLE_MAX;
        id_pool[0] = '0;
        id_pool[1] = ID_MAX;
        for (int i = 2; i < POOL_KEYS; i++)
        begin
            handle_pool[i] = rand_handle();
            id_pool[i] = {$urandom, $urandom};
        end
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        m_tready <= 1'b0;
        src_idle_pct = 15;
        dst_idle_pct = 74;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // two usable slots: fill, refusals in check order, lookups, release
        set_capacity(6'd1);
        push_op(cst_pkg::MODE_ALLOC, '0, '0);
        push_op(cst_pkg::MODE_ALLOC, HANDLE_MAX, ID_MAX);
        push_op(cst_pkg::MODE_ALLOC, 20'h12345, 64'h5555_5555_5555_5555);
        push_op(cst_pkg::MODE_ALLOC, '0, 64'hAAAA_AAAA_AAAA_AAAA);
        push_op(cst_pkg::MODE_ALLOC, 20'hABCDE, ID_MAX);
        push_op(cst_pkg::MODE_ALLOC, HANDLE_MAX, '0);
        push_op(cst_pkg::MODE_FIND_HANDLE, HANDLE_MAX, {$urandom, $urandom});
        push_op(cst_pkg::MODE_FIND_HANDLE, 20'h00001, {$urandom, $urandom});
        push_op(cst_pkg::MODE_FIND_ID, rand_handle(), '0);
        push_op(cst_pkg::MODE_FIND_ID, rand_handle(), 64'h1);
        push_op(cst_pkg::MODE_RELEASE, HANDLE_MAX, {$urandom, $urandom});
        push_op(cst_pkg::MODE_RELEASE, HANDLE_MAX, {$urandom, $urandom});
        push_op(cst_pkg::MODE_FIND_ID, rand_handle(), ID_MAX);
        push_op(cst_pkg::MODE_ALLOC, 20'h5A5A5, 64'hA5A5_A5A5_A5A5_A5A5);
        settle();

        // limit lowered below a live slot: it stays findable and releasable
        set_capacity(6'd0);
        push_op(cst_pkg::MODE_ALLOC, 20'h11111, 64'h2222_2222);
        push_op(cst_pkg::MODE_FIND_HANDLE, 20'h5A5A5, {$urandom, $urandom});
        push_op(cst_pkg::MODE_RELEASE, '0, {$urandom, $urandom});
        push_op(cst_pkg::MODE_ALLOC, 20'h11111, 64'h2222_2222);
        push_op(cst_pkg::MODE_ALLOC, 20'h33333, 64'h4444_4444);
        push_op(cst_pkg::MODE_RELEASE, 20'h5A5A5, {$urandom, $urandom});
        push_op(cst_pkg::MODE_FIND_ID, rand_handle(), 64'hA5A5_A5A5_A5A5_A5A5);
        push_op(cst_pkg::MODE_RELEASE, 20'h11111, {$urandom, $urandom});
        settle();

        set_capacity(6'd5);
        run_traffic(210, 50);
        settle();

        src_idle_pct = 74;
        dst_idle_pct = 15;
        set_capacity(6'd63);
        run_traffic(210, 70);
        settle();

        src_idle_pct = 0;
        dst_idle_pct = 0;
        set_capacity(6'd31);
        run_traffic(210, 45);
        settle();

        $display("ran %0d table operations at allocation limits 1, 0, 5, 63 and 31, peak %0d live",
                 table_model.ops_seen, table_model.peak_live);
        $display("refused: %0d handle in use, %0d id in use, %0d pool full, %0d not found",
                 table_model.status_seen[int'(cst_pkg::ST_HANDLE_USED)],
                 table_model.status_seen[int'(cst_pkg::ST_ID_USED)],
                 table_model.status_seen[int'(cst_pkg::ST_FULL)],
                 table_model.status_seen[int'(cst_pkg::ST_NOT_FOUND)]);
        if (table_model.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
